/* hw/rtl/mdfs_pkg.sv */
// Shared constants, codes and types for the multibyte delimiter field splitter.
// No dependencies.
`timescale 1ns / 1ps

package mdfs_pkg;

  localparam int MAX_DELIMITER_BYTES = 8;
  localparam int OFFSET_WIDTH        = 16;
  localparam int COUNT_WIDTH         = 16;
  localparam int LEN_WIDTH           = 4;
  localparam int SEL_WIDTH           = (MAX_DELIMITER_BYTES > 1) ? $clog2(MAX_DELIMITER_BYTES) : 1;
  localparam int WINDOW_BYTES        = (MAX_DELIMITER_BYTES > 1) ? MAX_DELIMITER_BYTES - 1 : 1;
  localparam int SINCE_WIDTH         = 4;

  localparam logic [SINCE_WIDTH-1:0] SINCE_NONE = SINCE_WIDTH'(8);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

  localparam int ADDR_WIDTH = 5;
  localparam logic [1:0] REG_DELIM_BYTES  = 2'd0;
  localparam logic [1:0] REG_DELIM_LENGTH = 2'd1;
  localparam logic [1:0] REG_FIELD_INDEX  = 2'd2;

  localparam logic [1:0] ST_DELIM = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic [63:0]            delim_bytes;
    logic [LEN_WIDTH-1:0]   delim_length;
    logic [15:0]            field_index;
  } mdfs_cfg_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [OFFSET_WIDTH-1:0] start;
    logic [OFFSET_WIDTH-1:0] stop;
    logic [COUNT_WIDTH-1:0]  count;
  } mdfs_entry_t;

endpackage

/* hw/rtl/mdfs_front.sv */
// Front end: takes bytes, runs the parallel delimiter window compare and tracks
// the chosen field; pushes one classified word per block. Uses mdfs_pkg.
`timescale 1ns / 1ps

module mdfs_front import mdfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mdfs_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_block_end,
  input  logic        q_full,
  output logic        q_push,
  output mdfs_entry_t q_entry
);

  logic [8*WINDOW_BYTES-1:0] window_r, window_nxt;
  logic [OFFSET_WIDTH-1:0]   pos_r, pos_nxt;
  logic [COUNT_WIDTH-1:0]    count_r, count_nxt;
  logic [SINCE_WIDTH-1:0]    since_r, since_nxt;
  logic [OFFSET_WIDTH-1:0]   start_r, start_nxt;
  logic [OFFSET_WIDTH-1:0]   stop_r, stop_nxt;
  logic                      closed_r, closed_nxt;

  logic [7:0]                     hist [MAX_DELIMITER_BYTES];
  logic [MAX_DELIMITER_BYTES-1:0] len_hit;
  logic [SEL_WIDTH-1:0]           len_sel;
  logic                           len_ok;
  logic                           hit;
  logic                           accept;
  logic [OFFSET_WIDTH:0]          pos_p1;
  logic [OFFSET_WIDTH-1:0]        pos_p1_sat;
  logic [OFFSET_WIDTH:0]          stop_wide;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    hist[0] = in_data_byte;
    for (int a = 1; a < MAX_DELIMITER_BYTES; a++) begin
      hist[a] = window_r[8*(a-1) +: 8];
    end
    for (int l = 1; l <= MAX_DELIMITER_BYTES; l++) begin
      len_hit[l-1] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (hist[l-1-k] != cfg.delim_bytes[8*k +: 8]) begin
          len_hit[l-1] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    len_ok     = (cfg.delim_length >= LEN_WIDTH'(1)) &&
                 (cfg.delim_length <= LEN_WIDTH'(MAX_DELIMITER_BYTES));
    len_sel    = SEL_WIDTH'(cfg.delim_length - LEN_WIDTH'(1));
    pos_p1     = {1'b0, pos_r} + (OFFSET_WIDTH+1)'(1);
    pos_p1_sat = pos_p1[OFFSET_WIDTH] ? OFFSET_MAX : pos_p1[OFFSET_WIDTH-1:0];
    stop_wide  = pos_p1 - (OFFSET_WIDTH+1)'(cfg.delim_length);
    hit = len_ok && (pos_p1 >= (OFFSET_WIDTH+1)'(cfg.delim_length)) &&
          (({1'b0, since_r} + (SINCE_WIDTH+1)'(1)) >= (SINCE_WIDTH+1)'(cfg.delim_length)) &&
          len_hit[len_sel];

    count_nxt  = count_r;
    since_nxt  = since_r;
    start_nxt  = start_r;
    stop_nxt   = stop_r;
    closed_nxt = closed_r;
    if (hit) begin
      if (({1'b0, count_r} + (COUNT_WIDTH+1)'(1)) == (COUNT_WIDTH+1)'(cfg.field_index)) begin
        start_nxt = pos_p1_sat;
      end
      if ((count_r == COUNT_WIDTH'(cfg.field_index)) && !closed_r) begin
        stop_nxt   = stop_wide[OFFSET_WIDTH-1:0];
        closed_nxt = 1'b1;
      end
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + COUNT_WIDTH'(1);
      end
      since_nxt = '0;
    end else if (since_r < SINCE_NONE) begin
      since_nxt = since_r + SINCE_WIDTH'(1);
    end
    if (MAX_DELIMITER_BYTES > 1) begin
      window_nxt = (8*WINDOW_BYTES)'({window_r, in_data_byte});
    end else begin
      window_nxt = '0;
    end
    pos_nxt = (pos_r != OFFSET_MAX) ? pos_r + OFFSET_WIDTH'(1) : pos_r;
  end

  always_comb begin
    q_push        = accept && in_block_end;
    q_entry.start = start_nxt;
    q_entry.stop  = closed_nxt ? stop_nxt : pos_nxt;
    q_entry.count = len_ok ? count_nxt : '0;
    if (!len_ok || (count_nxt < COUNT_WIDTH'(cfg.field_index))) begin
      q_entry.status = ST_ERROR;
    end else if (closed_nxt) begin
      q_entry.status = ST_DELIM;
    end else begin
      q_entry.status = ST_END;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_block_end)) begin
      window_r <= '0;
      pos_r    <= '0;
      count_r  <= '0;
      since_r  <= SINCE_NONE;
      start_r  <= '0;
      stop_r   <= '0;
      closed_r <= 1'b0;
    end else if (accept) begin
      window_r <= window_nxt;
      pos_r    <= pos_nxt;
      count_r  <= count_nxt;
      since_r  <= since_nxt;
      start_r  <= start_nxt;
      stop_r   <= stop_nxt;
      closed_r <= closed_nxt;
    end
  end

  a_since_range: assert property (@(posedge clk) disable iff (!rst_n)
    since_r <= SINCE_NONE)
    else $error("match distance out of range");

  a_block_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_block_end |=> pos_r == '0 && count_r == '0 && !closed_r)
    else $error("block state not cleared after last byte");

endmodule

/* hw/rtl/mdfs_queue.sv */
// Two-word queue between front and back ends.
// Uses mdfs_pkg for the entry type.
`timescale 1ns / 1ps

module mdfs_queue import mdfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mdfs_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output mdfs_entry_t head
);

  mdfs_entry_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

/* hw/rtl/mdfs_back.sv */
// Back end: turns a queued word into the final field report and holds it in
// the output register. Uses mdfs_pkg.
`timescale 1ns / 1ps

module mdfs_back import mdfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  mdfs_entry_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_field_start,
  output logic [15:0] out_field_length,
  output logic [15:0] out_match_count
);

  logic                    valid_r;
  logic [1:0]              status_r, status_nxt;
  logic [15:0]             start_r, start_nxt;
  logic [15:0]             length_r, length_nxt;
  logic [15:0]             count_r, count_nxt;
  logic [OFFSET_WIDTH-1:0] span;
  logic                    load;

  assign load  = q_valid && (!valid_r || !out_stall);
  assign q_pop = load;

  always_comb begin
    span       = (q_head.stop >= q_head.start) ? q_head.stop - q_head.start : '0;
    status_nxt = q_head.status;
    count_nxt  = 16'(q_head.count);
    if (q_head.status == ST_ERROR) begin
      start_nxt  = '0;
      length_nxt = '0;
    end else begin
      start_nxt  = 16'(q_head.start);
      length_nxt = 16'(span);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      start_r  <= start_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_field_start  = start_r;
  assign out_field_length = length_r;
  assign out_match_count  = count_r;

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (status_r == ST_ERROR) |-> (start_r == '0) && (length_r == '0))
    else $error("error word carries a field");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |-> !q_pop)
    else $error("stalled word overwritten");

endmodule

/* hw/rtl/multibyte_delimiter_field_splitter_core.sv */
// Multibyte delimiter field splitter. Takes one byte per cycle (in_valid/in_stall)
// unless the queue is full, so blocks stream back to back; each byte is checked by a
// parallel compare of the last eight bytes against the delimiter. One report word per
// block leaves on out_* after its last byte is taken, via the queue and the output
// register; a two-word queue between the byte front end and the report back end
// absorbs output stalls, and in_stall rises only when that queue is full.
// Registers over APB: delimiter bytes at 0x00, delimiter length at 0x08, field
// index at 0x10; change them only while no block is in flight.
`timescale 1ns / 1ps

module multibyte_delimiter_field_splitter_core import mdfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_block_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [15:0]           out_field_start,
  output logic [15:0]           out_field_length,
  output logic [15:0]           out_match_count
);

  logic [63:0]          delim_bytes_r;
  logic [LEN_WIDTH-1:0] delim_length_r;
  logic [15:0]          field_index_r;
  logic [1:0]           reg_sel;
  logic                 wr_en;
  mdfs_cfg_t            cfg;
  logic                 q_full, q_push, q_pop, q_valid;
  mdfs_entry_t          q_entry, q_head;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_bytes_r  <= '0;
      delim_length_r <= LEN_WIDTH'(1);
      field_index_r  <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DELIM_BYTES:  delim_bytes_r  <= pwdata;
        REG_DELIM_LENGTH: delim_length_r <= pwdata[LEN_WIDTH-1:0];
        REG_FIELD_INDEX:  field_index_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DELIM_BYTES:  prdata = delim_bytes_r;
      REG_DELIM_LENGTH: prdata = 64'(delim_length_r);
      REG_FIELD_INDEX:  prdata = 64'(field_index_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.delim_bytes  = delim_bytes_r;
  assign cfg.delim_length = delim_length_r;
  assign cfg.field_index  = field_index_r;

  mdfs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_block_end (in_block_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  mdfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  mdfs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_field_start  (out_field_start),
    .out_field_length (out_field_length),
    .out_match_count  (out_match_count)
  );

endmodule

/* verif/tb_top.sv */
// Self-checking bench for multibyte_delimiter_field_splitter_core: APB setup, a byte stream
// driven in bursts, and a scoreboard class that predicts one field report per block.
// Depends on mdfs_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
  import mdfs_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] count;
  } field_report_t;

  class field_split_scoreboard;
    logic [63:0]   delim;
    logic [3:0]    dlen;
    logic [15:0]   fidx;
    logic [55:0]   window;
    logic [15:0]   pos;
    logic [15:0]   match_cnt;
    logic [15:0]   cstart;
    logic [15:0]   cend;
    logic [3:0]    since;
    bit            closed;
    field_report_t pending_reports[$];
    int            errors;

    function new();
      delim  = '0;
      dlen   = 4'd1;
      fidx   = '0;
      errors = 0;
      clear_block();
    endfunction

    function void clear_block();
      window    = '0;
      pos       = '0;
      match_cnt = '0;
      since     = SINCE_NONE;
      cstart    = '0;
      cend      = '0;
      closed    = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_DELIM_BYTES:  delim = value;
        REG_DELIM_LENGTH: dlen  = value[3:0];
        REG_FIELD_INDEX:  fidx  = value[15:0];
        default: ;
      endcase
    endfunction

    // newest dlen bytes (current byte last) against the delimiter string
    function bit tail_matches(logic [7:0] b);
      int         age;
      logic [7:0] seen;
      for (int k = 0; k < int'(dlen); k++) begin
        age  = int'(dlen) - 1 - k;
        seen = (age == 0) ? b : window[8*(age-1) +: 8];
        if (seen != delim[8*k +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_byte(logic [7:0] b, bit last);
      bit            ok;
      int unsigned   m;
      field_report_t r;
      ok = dlen >= 1 && int'(dlen) <= MAX_DELIMITER_BYTES;
      if (ok && int'(pos) + 1 >= int'(dlen) && int'(since) + 1 >= int'(dlen)
          && tail_matches(b)) begin
        m = match_cnt;
        if (m + 1 == fidx) cstart = (pos == OFFSET_MAX) ? OFFSET_MAX : pos + 16'd1;
        if (m == fidx && !closed) begin
          cend   = 16'(int'(pos) + 1 - int'(dlen));
          closed = 1'b1;
        end
        if (match_cnt != COUNT_MAX) match_cnt++;
        since = '0;
      end else if (since < SINCE_NONE) begin
        since++;
      end
      window = {window[47:0], b};
      if (pos != OFFSET_MAX) pos++;
      if (!last) return;
      if (!ok) r = '{ST_ERROR, 16'd0, 16'd0, 16'd0};
      else if (match_cnt < fidx) r = '{ST_ERROR, 16'd0, 16'd0, match_cnt};
      else if (closed)
        r = '{ST_DELIM, cstart, (cend >= cstart) ? cend - cstart : 16'd0, match_cnt};
      else r = '{ST_END, cstart, (pos >= cstart) ? pos - cstart : 16'd0, match_cnt};
      pending_reports.push_back(r);
      clear_block();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_report(field_report_t got);
      field_report_t want;
      if (pending_reports.size() == 0) begin
        report($sformatf("report word with none expected (status %0d count %0d)",
                         got.status, got.count));
        return;
      end
      want = pending_reports.pop_front();
      if (got.status != want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.start != want.start)
        report($sformatf("field_start got %0d want %0d", got.start, want.start));
      if (got.len != want.len)
        report($sformatf("field_length got %0d want %0d", got.len, want.len));
      if (got.count != want.count)
        report($sformatf("match_count got %0d want %0d", got.count, want.count));
    endtask

    function bit drained();
      return pending_reports.size() == 0;
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr        = '0;
  logic [63:0]           pwdata       = '0;
  logic [63:0]           prdata;
  logic                  pready;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = '0;
  logic                  in_block_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [1:0]            out_status;
  logic [15:0]           out_field_start;
  logic [15:0]           out_field_length;
  logic [15:0]           out_match_count;

  field_split_scoreboard sb = new();
  field_report_t         seen_report;
  logic [7:0]            block_bytes[$];
  bit                    steady      = 1'b0;
  int                    burst_left  = 1;
  int                    hold_req    = 0;
  int                    hold_served = 0;
  int                    cycles      = 0;

  multibyte_delimiter_field_splitter_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_block_end     (in_block_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_field_start  (out_field_start),
    .out_field_length (out_field_length),
    .out_match_count  (out_match_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_report = '{out_status, out_field_start, out_field_length, out_match_count};
      sb.check_report(seen_report);
    end
  end

  // receiver: free-running stall pattern, plus long hold-offs on request
  initial begin
    int mode;
    int run;
    wait (rst_n);
    forever begin
      if (hold_req != hold_served) begin
        hold_served++;
        repeat (LONG_HOLD) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 3);
        run  = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(1, 40);
        repeat (run) begin
          @(posedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= $urandom_range(0, 1);
            2: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= 1'b1;
          endcase
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WIDTH'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task automatic configure(input logic [63:0] delim, input logic [3:0] dlen,
                           input logic [15:0] fidx);
    write_reg(REG_DELIM_BYTES, delim);
    write_reg(REG_DELIM_LENGTH, {60'd0, dlen});
    write_reg(REG_FIELD_INDEX, {48'd0, fidx});
  endtask

  task automatic push_byte(input logic [7:0] b, input bit last);
    int gap;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_block_end <= last;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b, last);
    if (!steady) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic send_block();
    for (int i = 0; i < block_bytes.size(); i++)
      push_byte(block_bytes[i], i == block_bytes.size() - 1);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (!sb.drained()) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // block of roughly target bytes, rich in whole and partial delimiters
  task automatic make_block(input int target);
    int pick;
    int span;
    int n;
    span = (sb.dlen == 0) ? 1 : (sb.dlen > 8) ? 8 : int'(sb.dlen);
    block_bytes.delete();
    while (block_bytes.size() < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        for (int k = 0; k < span; k++) block_bytes.push_back(sb.delim[8*k +: 8]);
      end else if (pick < 5) begin
        n = $urandom_range(1, span);
        for (int k = 0; k < n; k++) block_bytes.push_back(sb.delim[8*k +: 8]);
      end else if (pick < 8) begin
        n = $urandom_range(0, span - 1);
        block_bytes.push_back(sb.delim[8*n +: 8]);
      end else begin
        block_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic random_config();
    logic [63:0] delim;
    logic [3:0]  dlen;
    logic [15:0] fidx;
    int          r;
    for (int k = 0; k < 8; k++)
      delim[8*k +: 8] = $urandom_range(0, 1) ? 8'(8'h61 + $urandom_range(0, 2))
                                             : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 11);
    if (r < 10) dlen = 4'(1 + r % 8);
    else if (r == 10) dlen = 4'd0;
    else dlen = 4'($urandom_range(9, 15));
    r = $urandom_range(0, 9);
    if (r < 7) fidx = 16'($urandom_range(0, 3));
    else if (r < 9) fidx = 16'($urandom_range(4, 12));
    else fidx = 16'($urandom_range(0, 65535));
    configure(delim, dlen, fidx);
  endtask

  initial begin
    int items;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two-byte delimiter, field 1: closed field, too few, empty field, field at end
    configure(64'h6261, 4'd2, 16'd1);
    block_bytes = '{8'h78, 8'h61, 8'h62, 8'h79, 8'h61, 8'h62, 8'h7a};
    send_block();
    block_bytes = '{8'h71};
    send_block();
    block_bytes = '{8'h61, 8'h62, 8'h61, 8'h62};
    send_block();
    block_bytes = '{8'h61, 8'h62};
    send_block();
    drain_and_settle();

    // self-overlapping delimiter: matches must not share bytes
    configure(64'h616161, 4'd3, 16'd0);
    block_bytes = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61};
    send_block();
    drain_and_settle();

    configure('1, 4'd8, 16'hffff);
    block_bytes = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00};
    send_block();
    drain_and_settle();

    // bad delimiter lengths
    configure('0, 4'd0, 16'd0);
    block_bytes = '{8'h00, 8'h00};
    send_block();
    drain_and_settle();
    configure('0, 4'd9, 16'd0);
    block_bytes = '{8'h00};
    send_block();
    drain_and_settle();
    configure('0, 4'd15, 16'd1);
    block_bytes = '{8'h00, 8'h00, 8'h00};
    send_block();
    drain_and_settle();

    for (int ph = 0; ph < 9; ph++) begin
      random_config();
      items = 0;
      if (ph == 4) begin
        // receiver holds off while short blocks keep coming
        hold_req++;
        steady = 1'b1;
        for (int i = 0; i < 48; i++) begin
          make_block($urandom_range(1, 2));
          send_block();
          items += block_bytes.size();
        end
        steady = 1'b0;
        drain_and_settle();
      end
      while (items < 110) begin
        make_block(($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 16));
        send_block();
        items += block_bytes.size();
      end
      drain_and_settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* multibyte_delimiter_field_splitter_core.f */
hw/rtl/mdfs_pkg.sv
hw/rtl/mdfs_front.sv
hw/rtl/mdfs_queue.sv
hw/rtl/mdfs_back.sv
hw/rtl/multibyte_delimiter_field_splitter_core.sv
verif/tb_top.sv
